// ----- rtl/doubly_linked_list_engine_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the doubly linked list engine
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_ENGINE_UNIT_DEFINES_SVH
`define DOUBLY_LINKED_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DLL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dll check failed");
`define DLL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dll check failed");
`else
`define DLL_ASSERT_IMPL(lbl, ante, cons)
`define DLL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/dll_pkg.sv -----
// ----------------------------------------------------------------------------
// Doubly linked list engine package
// Sizes, link encoding, operation codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dll_pkg;

  localparam int NODE_COUNT  = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int DATA_W      = 32;
  localparam int OP_W        = 5;
  localparam int ADDR_W      = $clog2(NODE_COUNT);
  localparam int LINK_W      = $clog2(NODE_COUNT + 1);

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NODE_COUNT);

  typedef logic [LINK_W-1:0]      link_t;
  typedef logic [VALUE_WIDTH-1:0] node_val_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 5'd0,
    OP_INS_HEAD   = 5'd1,
    OP_INS_TAIL   = 5'd2,
    OP_CUR_HEAD   = 5'd3,
    OP_CUR_TAIL   = 5'd4,
    OP_RD_HEAD    = 5'd5,
    OP_RD_TAIL    = 5'd6,
    OP_DEL_HEAD   = 5'd7,
    OP_DEL_TAIL   = 5'd8,
    OP_DEL_AFTER  = 5'd9,
    OP_DEL_BEFORE = 5'd10,
    OP_INS_AFTER  = 5'd11,
    OP_INS_BEFORE = 5'd12,
    OP_RD_CUR     = 5'd13,
    OP_WR_CUR     = 5'd14,
    OP_NEXT       = 5'd15,
    OP_PREV       = 5'd16
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_R1,
    S_R2,
    S_R3,
    S_W1,
    S_W2
  } state_e;

  function automatic logic is_link(link_t l);
    return l < NIL_LINK;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/doubly_linked_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Doubly linked list engine
// A linked list of signed values in a node pool, with head, tail and cursor.
// ----------------------------------------------------------------------------
// Each input word carries an operation code and a value; each one yields
// exactly one output word with the read value, an error flag, the cursor
// activity and the empty flag after the operation.
// Both channels use valid and ready. A word is taken only while the engine
// is idle and its output register is empty or being emptied.
// Every operation runs the same sequence: two reads of the node memories
// (the first at head, tail or cursor, the second at the neighbour or the
// free list head), a wait for the registered read data, and two write
// steps. The result word is registered as the engine leaves S_W2 and the
// next word is taken only once it is back in S_IDLE, so no word is taken
// before the last is done; the node memories have a single read port.
// Reset empties the list, the free list and the fresh allocator at once;
// the node memories are not cleared. When the receiver stalls, the result
// stays in the output register and no new word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "doubly_linked_list_engine_unit_defines.svh"

module doubly_linked_list_engine_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [dll_pkg::OP_W-1:0]   operation_i,
  input  wire logic signed [dll_pkg::DATA_W-1:0] value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [dll_pkg::DATA_W-1:0] read_value_o,
  output logic                            error_o,
  output logic                            active_o,
  output logic                            empty_res_o
);

  import dll_pkg::*;

  node_val_t val_mem  [NODE_COUNT];
  link_t     prev_mem [NODE_COUNT];
  link_t     next_mem [NODE_COUNT];

  state_e    state_q, state_d;
  op_e       op_q;
  node_val_t val_q;
  link_t     head_q, tail_q, cur_q, free_q, fresh_q;
  link_t     nh, nt, nc, nf, nm;

  node_val_t rd_val_q, r1_val_q;
  link_t     rd_prev_q, rd_next_q, r1_prev_q, r1_next_q, r2_prev_q, r2_next_q;
  link_t     raddr;

  logic      v_we, p_we, n_we;
  link_t     v_wa, p_wa, n_wa, p_wd, n_wd;
  node_val_t v_wd;

  logic      in_fire, free_ok, can_alloc, end_t_ok, cur_ok;
  link_t     new_node, alloc_free, alloc_fresh, end_t;
  logic signed [DATA_W-1:0] rdv;
  logic      er;

  logic signed [DATA_W-1:0] read_value_q;
  logic      out_valid_q, error_q, active_q, empty_q;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign free_ok     = is_link(free_q);
  assign can_alloc   = free_ok || (fresh_q < NIL_LINK);
  assign new_node    = free_ok ? free_q : fresh_q;
  assign alloc_free  = free_ok ? r2_next_q : free_q;
  assign alloc_fresh = free_ok ? fresh_q : fresh_q + LINK_W'(1);
  assign end_t       = (op_q == OP_DEL_HEAD) ? head_q : tail_q;
  assign end_t_ok    = is_link(end_t);
  assign cur_ok      = is_link(cur_q);

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      val_mem[v_wa[ADDR_W-1:0]] <= v_wd;
    end
    if (p_we) begin
      prev_mem[p_wa[ADDR_W-1:0]] <= p_wd;
    end
    if (n_we) begin
      next_mem[n_wa[ADDR_W-1:0]] <= n_wd;
    end
    rd_val_q  <= val_mem[raddr[ADDR_W-1:0]];
    rd_prev_q <= prev_mem[raddr[ADDR_W-1:0]];
    rd_next_q <= next_mem[raddr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(operation_i);
      val_q <= VALUE_WIDTH'(value_i);
    end
    if (state_q == S_R2) begin
      r1_val_q  <= rd_val_q;
      r1_prev_q <= rd_prev_q;
      r1_next_q <= rd_next_q;
    end
    if (state_q == S_R3) begin
      r2_prev_q <= rd_prev_q;
      r2_next_q <= rd_next_q;
    end
    if (state_q == S_W2) begin
      read_value_q <= rdv;
      error_q      <= er;
      active_q     <= is_link(nc);
      empty_q      <= !is_link(nh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= NIL_LINK;
      tail_q      <= NIL_LINK;
      cur_q       <= NIL_LINK;
      free_q      <= NIL_LINK;
      fresh_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_W2) begin
        out_valid_q <= 1'b1;
        head_q      <= nh;
        tail_q      <= nt;
        cur_q       <= nc;
        free_q      <= nf;
        fresh_q     <= nm;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    raddr   = NIL_LINK;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_R1;
      end
      S_R1: begin
        if (op_q == OP_RD_HEAD || op_q == OP_DEL_HEAD) begin
          raddr = head_q;
        end else if (op_q == OP_RD_TAIL || op_q == OP_DEL_TAIL) begin
          raddr = tail_q;
        end else begin
          raddr = cur_q;
        end
        state_d = S_R2;
      end
      S_R2: begin
        if (op_q == OP_DEL_AFTER) begin
          raddr = rd_next_q;
        end else if (op_q == OP_DEL_BEFORE) begin
          raddr = rd_prev_q;
        end else begin
          raddr = free_q;
        end
        state_d = S_R3;
      end
      S_R3: state_d = S_W1;
      S_W1: state_d = S_W2;
      S_W2: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    nh  = head_q;
    nt  = tail_q;
    nc  = cur_q;
    nf  = free_q;
    nm  = fresh_q;
    rdv = '0;
    er  = 1'b0;
    unique case (op_q)
      OP_CLEAR: begin
        nh = NIL_LINK;
        nt = NIL_LINK;
        nc = NIL_LINK;
        nf = NIL_LINK;
        nm = '0;
      end
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (!can_alloc) begin
          er = 1'b1;
        end else begin
          nf = alloc_free;
          nm = alloc_fresh;
          if (!is_link(head_q)) begin
            nh = new_node;
            nt = new_node;
          end else if (op_q == OP_INS_HEAD) begin
            nh = new_node;
          end else begin
            nt = new_node;
          end
        end
      end
      OP_CUR_HEAD: nc = head_q;
      OP_CUR_TAIL: nc = tail_q;
      OP_RD_HEAD, OP_RD_TAIL: begin
        if ((op_q == OP_RD_HEAD) ? is_link(head_q) : is_link(tail_q)) begin
          rdv = DATA_W'(signed'(r1_val_q));
        end else begin
          er = 1'b1;
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL: begin
        if (end_t_ok) begin
          if (cur_q == end_t) nc = NIL_LINK;
          if (head_q == tail_q) begin
            nh = NIL_LINK;
            nt = NIL_LINK;
          end else if (op_q == OP_DEL_HEAD) begin
            nh = r1_next_q;
          end else begin
            nt = r1_prev_q;
          end
          nf = end_t;
        end
      end
      OP_DEL_AFTER: begin
        if (cur_ok && cur_q != tail_q) begin
          if (r1_next_q == tail_q) nt = cur_q;
          nf = r1_next_q;
        end
      end
      OP_DEL_BEFORE: begin
        if (cur_ok && cur_q != head_q) begin
          if (r1_prev_q == head_q) nh = cur_q;
          nf = r1_prev_q;
        end
      end
      OP_INS_AFTER, OP_INS_BEFORE: begin
        if (cur_ok) begin
          if (!can_alloc) begin
            er = 1'b1;
          end else begin
            nf = alloc_free;
            nm = alloc_fresh;
            if (op_q == OP_INS_AFTER && cur_q == tail_q) nt = new_node;
            if (op_q == OP_INS_BEFORE && cur_q == head_q) nh = new_node;
          end
        end
      end
      OP_RD_CUR: begin
        if (cur_ok) begin
          rdv = DATA_W'(signed'(r1_val_q));
        end else begin
          er = 1'b1;
        end
      end
      OP_NEXT: begin
        if (cur_ok) nc = (cur_q == tail_q) ? NIL_LINK : r1_next_q;
      end
      OP_PREV: begin
        if (cur_ok) nc = (cur_q == head_q) ? NIL_LINK : r1_prev_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    v_we = 1'b0;
    p_we = 1'b0;
    n_we = 1'b0;
    v_wa = new_node;
    p_wa = new_node;
    n_wa = new_node;
    v_wd = val_q;
    p_wd = NIL_LINK;
    n_wd = NIL_LINK;
    if (state_q == S_W1) begin
      case (op_q)
        OP_INS_HEAD, OP_INS_TAIL: begin
          if (can_alloc) begin
            v_we = 1'b1;
            p_we = 1'b1;
            n_we = 1'b1;
            if (op_q == OP_INS_TAIL && is_link(head_q)) p_wd = tail_q;
            if (op_q == OP_INS_HEAD && is_link(head_q)) n_wd = head_q;
          end
        end
        OP_DEL_HEAD: begin
          if (end_t_ok && head_q != tail_q) begin
            p_we = 1'b1;
            p_wa = r1_next_q;
          end
        end
        OP_DEL_TAIL: begin
          if (end_t_ok && head_q != tail_q) begin
            n_we = 1'b1;
            n_wa = r1_prev_q;
          end
        end
        OP_DEL_AFTER: begin
          if (cur_ok && cur_q != tail_q) begin
            n_we = 1'b1;
            n_wa = cur_q;
            n_wd = r2_next_q;
            p_we = (r1_next_q != tail_q);
            p_wa = r2_next_q;
            p_wd = cur_q;
          end
        end
        OP_DEL_BEFORE: begin
          if (cur_ok && cur_q != head_q) begin
            p_we = 1'b1;
            p_wa = cur_q;
            p_wd = r2_prev_q;
            n_we = (r1_prev_q != head_q);
            n_wa = r2_prev_q;
            n_wd = cur_q;
          end
        end
        OP_INS_AFTER, OP_INS_BEFORE: begin
          if (cur_ok && can_alloc) begin
            v_we = 1'b1;
            p_we = 1'b1;
            n_we = 1'b1;
            p_wd = (op_q == OP_INS_AFTER) ? cur_q : r1_prev_q;
            n_wd = (op_q == OP_INS_AFTER) ? r1_next_q : cur_q;
          end
        end
        OP_WR_CUR: begin
          if (cur_ok) begin
            v_we = 1'b1;
            v_wa = cur_q;
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == S_W2) begin
      case (op_q)
        OP_INS_HEAD: begin
          if (can_alloc && is_link(head_q)) begin
            p_we = 1'b1;
            p_wa = head_q;
            p_wd = new_node;
          end
        end
        OP_INS_TAIL: begin
          if (can_alloc && is_link(head_q)) begin
            n_we = 1'b1;
            n_wa = tail_q;
            n_wd = new_node;
          end
        end
        OP_DEL_HEAD, OP_DEL_TAIL: begin
          if (end_t_ok) begin
            n_we = 1'b1;
            n_wa = end_t;
            n_wd = free_q;
          end
        end
        OP_DEL_AFTER: begin
          if (cur_ok && cur_q != tail_q) begin
            n_we = 1'b1;
            n_wa = r1_next_q;
            n_wd = free_q;
          end
        end
        OP_DEL_BEFORE: begin
          if (cur_ok && cur_q != head_q) begin
            n_we = 1'b1;
            n_wa = r1_prev_q;
            n_wd = free_q;
          end
        end
        OP_INS_AFTER: begin
          if (cur_ok && can_alloc) begin
            n_we = 1'b1;
            n_wa = cur_q;
            n_wd = new_node;
            p_we = (cur_q != tail_q);
            p_wa = r1_next_q;
            p_wd = new_node;
          end
        end
        OP_INS_BEFORE: begin
          if (cur_ok && can_alloc) begin
            p_we = 1'b1;
            p_wa = cur_q;
            p_wd = new_node;
            n_we = (cur_q != head_q);
            n_wa = r1_prev_q;
            n_wd = new_node;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign error_o      = error_q;
  assign active_o     = active_q;
  assign empty_res_o  = empty_q;

  `DLL_ASSERT_NEXT(a_accept_starts, in_fire, state_q == S_R1)
  `DLL_ASSERT_IMPL(a_ends_agree, 1'b1, is_link(head_q) == is_link(tail_q))
  `DLL_ASSERT_IMPL(a_err_no_data, out_valid_o && error_o, read_value_o == '0)
  `DLL_ASSERT_IMPL(a_empty_inactive, out_valid_o && empty_res_o, !active_o)

endmodule

`default_nettype wire

// ----- verif/doubly_linked_list_engine_unit_test.sv -----
// ----------------------------------------------------------------------------
// Doubly linked list engine testbench
// Drives operation words into the engine, keeps its own model of the list
// (node pool, free list, head, tail and cursor) and checks every result word
// against the predicted read value, error flag, activity and empty flag.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dll_pkg::*;

  typedef struct packed {
    logic signed [31:0] rd;
    logic               err;
    logic               act;
    logic               emp;
  } list_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [OP_W-1:0] operation_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] read_value_o;
  logic error_o, active_o, empty_res_o;

  doubly_linked_list_engine_unit u_dut (.*);

  always #5 clk_i = ~clk_i;

  logic [31:0] pool_val [NODE_COUNT];
  int unsigned pool_prev [NODE_COUNT];
  int unsigned pool_next [NODE_COUNT];
  int unsigned head_q, tail_q, cur_q, free_q, fresh_q;
  list_res_t expected_words[$];
  int unsigned fail_count = 0;
  int unsigned word_count = 0;
  int unsigned result_count = 0;
  int unsigned error_count = 0;
  bit quiet = 1'b0;

  function automatic bit is_node(int unsigned i);
    return i < NODE_COUNT;
  endfunction

  function automatic void list_clear();
    head_q = NODE_COUNT; tail_q = NODE_COUNT; cur_q = NODE_COUNT;
    free_q = NODE_COUNT; fresh_q = 0;
  endfunction

  function automatic int unsigned take_node(logic [31:0] v);
    int unsigned n;
    if (is_node(free_q)) begin
      n = free_q;
      free_q = pool_next[n];
    end else if (fresh_q < NODE_COUNT) begin
      n = fresh_q;
      fresh_q++;
    end else begin
      return NODE_COUNT;
    end
    pool_val[n] = v;
    pool_prev[n] = NODE_COUNT;
    pool_next[n] = NODE_COUNT;
    return n;
  endfunction

  function automatic void give_node(int unsigned n);
    pool_next[n] = free_q;
    free_q = n;
  endfunction

  function automatic list_res_t list_apply(op_e op, logic [31:0] v);
    list_res_t r;
    int unsigned n, t, a;
    r = '0;
    a = cur_q;
    case (op)
      OP_CLEAR: list_clear();
      OP_INS_HEAD, OP_INS_TAIL: begin
        n = take_node(v);
        if (!is_node(n)) r.err = 1'b1;
        else if (!is_node(head_q)) begin
          head_q = n; tail_q = n;
        end else if (op == OP_INS_HEAD) begin
          pool_next[n] = head_q; pool_prev[head_q] = n; head_q = n;
        end else begin
          pool_prev[n] = tail_q; pool_next[tail_q] = n; tail_q = n;
        end
      end
      OP_CUR_HEAD: cur_q = head_q;
      OP_CUR_TAIL: cur_q = tail_q;
      OP_RD_HEAD, OP_RD_TAIL: begin
        t = (op == OP_RD_HEAD) ? head_q : tail_q;
        if (!is_node(t)) r.err = 1'b1; else r.rd = pool_val[t];
      end
      OP_DEL_HEAD, OP_DEL_TAIL: begin
        t = (op == OP_DEL_HEAD) ? head_q : tail_q;
        if (is_node(t)) begin
          if (cur_q == t) cur_q = NODE_COUNT;
          if (head_q == tail_q) begin
            head_q = NODE_COUNT; tail_q = NODE_COUNT;
          end else if (op == OP_DEL_HEAD) begin
            head_q = pool_next[t]; pool_prev[head_q] = NODE_COUNT;
          end else begin
            tail_q = pool_prev[t]; pool_next[tail_q] = NODE_COUNT;
          end
          give_node(t);
        end
      end
      OP_DEL_AFTER: if (is_node(a) && a != tail_q) begin
        t = pool_next[a];
        pool_next[a] = pool_next[t];
        if (t == tail_q) tail_q = a; else pool_prev[pool_next[t]] = a;
        give_node(t);
      end
      OP_DEL_BEFORE: if (is_node(a) && a != head_q) begin
        t = pool_prev[a];
        pool_prev[a] = pool_prev[t];
        if (t == head_q) head_q = a; else pool_next[pool_prev[t]] = a;
        give_node(t);
      end
      OP_INS_AFTER: if (is_node(a)) begin
        n = take_node(v);
        if (!is_node(n)) r.err = 1'b1;
        else begin
          pool_prev[n] = a; pool_next[n] = pool_next[a];
          if (a == tail_q) tail_q = n; else pool_prev[pool_next[a]] = n;
          pool_next[a] = n;
        end
      end
      OP_INS_BEFORE: if (is_node(a)) begin
        n = take_node(v);
        if (!is_node(n)) r.err = 1'b1;
        else begin
          pool_next[n] = a; pool_prev[n] = pool_prev[a];
          if (a == head_q) head_q = n; else pool_next[pool_prev[a]] = n;
          pool_prev[a] = n;
        end
      end
      OP_RD_CUR: if (!is_node(a)) r.err = 1'b1; else r.rd = pool_val[a];
      OP_WR_CUR: if (is_node(a)) pool_val[a] = v;
      OP_NEXT: if (is_node(a)) cur_q = (a == tail_q) ? NODE_COUNT : pool_next[a];
      OP_PREV: if (is_node(a)) cur_q = (a == head_q) ? NODE_COUNT : pool_prev[a];
      default: ;
    endcase
    r.act = is_node(cur_q);
    r.emp = !is_node(head_q);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h", result_count, what, got, want);
    fail_count++;
  endtask

  task automatic send_word(logic [4:0] op, logic [31:0] v);
    list_res_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    r = list_apply(op_e'(op), v);
    expected_words.push_back(r);
    if (r.err) error_count++;
    in_valid_i <= 1'b1;
    operation_i <= op;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    word_count++;
  endtask

  always @(posedge clk_i) begin
    list_res_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("unexpected result word %0d", result_count);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (read_value_o !== want.rd) report_mismatch("read_value", read_value_o, want.rd);
        if (error_o !== want.err) report_mismatch("error", 32'(error_o), 32'(want.err));
        if (active_o !== want.act) report_mismatch("active", 32'(active_o), 32'(want.act));
        if (empty_res_o !== want.emp) begin
          report_mismatch("empty_res", 32'(empty_res_o), 32'(want.emp));
        end
      end
      result_count++;
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_ready_i <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_list();
    send_word(OP_RD_HEAD, 0);
    send_word(OP_RD_TAIL, 0);
    send_word(OP_RD_CUR, 0);
    send_word(OP_DEL_HEAD, 0);
    send_word(OP_DEL_TAIL, 0);
    send_word(OP_CUR_HEAD, 0);
    send_word(OP_NEXT, 0);
    send_word(OP_INS_AFTER, 32'h1234);
    send_word(5'd31, 32'hffff_ffff);
  endtask

  task automatic test_directed_ops();
    send_word(OP_INS_HEAD, 32'h8000_0000);
    send_word(OP_INS_TAIL, 32'h7fff_ffff);
    send_word(OP_CUR_HEAD, 0);
    send_word(OP_INS_AFTER, 32'hffff_ffff);
    send_word(OP_INS_BEFORE, 32'h0);
    send_word(OP_NEXT, 0);
    send_word(OP_WR_CUR, 32'h5a5a_a5a5);
    send_word(OP_RD_CUR, 0);
    send_word(OP_DEL_BEFORE, 0);
    send_word(OP_DEL_AFTER, 0);
    send_word(OP_CUR_TAIL, 0);
    send_word(OP_DEL_AFTER, 0);
    send_word(OP_RD_TAIL, 0);
    send_word(OP_DEL_TAIL, 0);
    send_word(OP_RD_HEAD, 0);
    send_word(OP_CUR_HEAD, 0);
    send_word(OP_PREV, 0);
    send_word(OP_DEL_HEAD, 0);
    send_word(5'd17, 0);
    send_word(OP_CLEAR, 0);
  endtask

  task automatic test_full_pool();
    for (int i = 0; i < NODE_COUNT + 2; i++) send_word(OP_INS_TAIL, rand_value());
    send_word(OP_CUR_HEAD, 0);
    send_word(OP_INS_AFTER, 1);
    send_word(OP_INS_BEFORE, 2);
    send_word(OP_DEL_AFTER, 0);
    send_word(OP_INS_BEFORE, 3);
    send_word(OP_RD_HEAD, 0);
    send_word(OP_CLEAR, 0);
  endtask

  task automatic test_random_ops(int unsigned count);
    logic [4:0] op;
    for (int unsigned i = 0; i < count; i++) begin
      if (i >= count - 60) quiet = 1'b1;
      case ($urandom_range(0, 19))
        0: op = (is_node(head_q)) ? 5'($urandom_range(17, 31)) : 5'(OP_CLEAR);
        1, 2, 3: op = 5'($urandom_range(OP_INS_HEAD, OP_INS_TAIL));
        4: op = 5'($urandom_range(OP_CUR_HEAD, OP_CUR_TAIL));
        default: op = 5'($urandom_range(OP_INS_HEAD, OP_PREV));
      endcase
      if (op == OP_CLEAR && $urandom_range(0, 3) != 0) op = 5'(OP_INS_TAIL);
      send_word(op, rand_value());
    end
  endtask

  initial begin
    for (int i = 0; i < NODE_COUNT; i++) begin
      pool_val[i] = '0; pool_prev[i] = NODE_COUNT; pool_next[i] = NODE_COUNT;
    end
    list_clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_directed_ops();
    test_full_pool();
    test_random_ops(400);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d words and %0d results, %0d of them flagged errors,",
             word_count, result_count, error_count);
    $display("including empty-list, full-pool and cursor edge cases.");
    if (fail_count == 0) begin
      $display("doubly_linked_list_engine_unit_test OK");
    end else begin
      $display("doubly_linked_list_engine_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("doubly_linked_list_engine_unit_test NOT OK");
    $finish;
  end
endmodule

// ----- doubly_linked_list_engine_unit.f -----
+incdir+rtl
rtl/dll_pkg.sv
rtl/doubly_linked_list_engine_unit.sv
verif/doubly_linked_list_engine_unit_test.sv
